### design/bmhq_pkg.sv
package bmhq_pkg;

    localparam int DEPTH  = 1024;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int FILL_W = 11;
    localparam int DATA_W = 32;

    typedef logic [ADDR_W-1:0]        t_addr;
    typedef logic [ADDR_W:0]          t_child;
    typedef logic [CNT_W-1:0]         t_cnt;
    typedef logic [FILL_W-1:0]        t_fill;
    typedef logic signed [DATA_W-1:0] t_data;
    typedef logic [1:0]               t_func;
    typedef logic [1:0]               t_status;

    localparam t_func FUNC_PUSH = 2'd0;
    localparam t_func FUNC_POP  = 2'd1;

    localparam t_status ST_OK    = 2'd0;
    localparam t_status ST_EMPTY = 2'd1;
    localparam t_status ST_FULL  = 2'd2;

    localparam t_cnt DEPTH_CNT = t_cnt'(DEPTH);

    typedef struct packed {
        t_func func;
        t_data push_value;
    } t_in;

    typedef struct packed {
        t_data   top_value;
        t_status status;
        t_fill   fill_level;
    } t_out;

    typedef struct packed {
        logic start;
        t_in  item;
    } t_req;

    typedef struct packed {
        logic valid;
        t_out item;
    } t_res;

endpackage

### design/bmhq_core.sv
module bmhq_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  bmhq_pkg::t_req i_req,
    input  logic           i_res_take,
    output logic           o_busy,
    output bmhq_pkg::t_res o_res
);
    import bmhq_pkg::*;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_UP       = 4'd1;
    localparam logic [3:0] S_UP_CMP   = 4'd2;
    localparam logic [3:0] S_POP_ROOT = 4'd3;
    localparam logic [3:0] S_POP_LAST = 4'd4;
    localparam logic [3:0] S_DN       = 4'd5;
    localparam logic [3:0] S_DN_L     = 4'd6;
    localparam logic [3:0] S_DN_R     = 4'd7;
    localparam logic [3:0] S_PEEK     = 4'd8;
    localparam logic [3:0] S_DONE     = 4'd9;

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    logic [3:0] r_state, n_state;
    t_cnt       r_cnt, n_cnt;
    t_addr      r_pos, n_pos;
    t_data      r_mov, n_mov;
    t_data      r_lval, n_lval;
    logic       r_lless, n_lless;
    t_data      r_top, n_top;
    t_status    r_status, n_status;

    logic  mem_we;
    t_addr mem_waddr;
    t_data mem_wdata;
    t_addr mem_raddr;

    t_data  rd_val;
    t_addr  parent;
    t_child left_idx;
    t_child right_idx;
    t_data  best_val;

    assign rd_val    = $signed(r_rd_data);
    assign parent    = (r_pos - t_addr'(1)) >> 1;
    assign left_idx  = {r_pos, 1'b1};
    assign right_idx = left_idx + t_child'(1);
    assign best_val  = r_lless ? r_lval : r_mov;

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_pos     = r_pos;
        n_mov     = r_mov;
        n_lval    = r_lval;
        n_lless   = r_lless;
        n_top     = r_top;
        n_status  = r_status;
        mem_we    = 1'b0;
        mem_waddr = r_pos;
        mem_wdata = r_mov;
        mem_raddr = '0;
        case (r_state)
            S_IDLE: begin
                if (i_req.start) begin
                    n_top    = '0;
                    n_status = ST_OK;
                    case (i_req.item.func)
                        FUNC_PUSH: begin
                            if (r_cnt >= DEPTH_CNT) begin
                                n_status = ST_FULL;
                                n_state  = S_DONE;
                            end else begin
                                n_pos   = t_addr'(r_cnt);
                                n_mov   = i_req.item.push_value;
                                n_cnt   = r_cnt + t_cnt'(1);
                                n_state = S_UP;
                            end
                        end
                        FUNC_POP: begin
                            if (r_cnt == '0) begin
                                n_top    = '1;
                                n_status = ST_EMPTY;
                                n_state  = S_DONE;
                            end else begin
                                n_cnt   = r_cnt - t_cnt'(1);
                                n_state = S_POP_ROOT;
                            end
                        end
                        default: begin
                            if (r_cnt == '0) begin
                                n_top    = '1;
                                n_status = ST_EMPTY;
                                n_state  = S_DONE;
                            end else begin
                                n_state = S_PEEK;
                            end
                        end
                    endcase
                end
            end
            S_UP: begin
                if (r_pos == '0) begin
                    mem_we  = 1'b1;
                    n_state = S_DONE;
                end else begin
                    mem_raddr = parent;
                    n_state   = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                mem_we = 1'b1;
                if (r_mov < rd_val) begin
                    mem_wdata = rd_val;
                    n_pos     = parent;
                    n_state   = S_UP;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_POP_ROOT: begin
                n_top     = rd_val;
                mem_raddr = t_addr'(r_cnt);
                n_state   = S_POP_LAST;
            end
            S_POP_LAST: begin
                n_mov   = rd_val;
                n_pos   = '0;
                n_state = S_DN;
            end
            S_DN: begin
                if (left_idx >= t_child'(r_cnt)) begin
                    mem_we  = 1'b1;
                    n_state = S_DONE;
                end else begin
                    mem_raddr = t_addr'(left_idx);
                    n_state   = S_DN_L;
                end
            end
            S_DN_L: begin
                n_lval  = rd_val;
                n_lless = rd_val < r_mov;
                if (right_idx < t_child'(r_cnt)) begin
                    mem_raddr = t_addr'(right_idx);
                    n_state   = S_DN_R;
                end else begin
                    mem_we = 1'b1;
                    if (rd_val < r_mov) begin
                        mem_wdata = rd_val;
                        n_pos     = t_addr'(left_idx);
                        n_state   = S_DN;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_DN_R: begin
                mem_we = 1'b1;
                if (rd_val < best_val) begin
                    mem_wdata = rd_val;
                    n_pos     = t_addr'(right_idx);
                    n_state   = S_DN;
                end else if (r_lless) begin
                    mem_wdata = r_lval;
                    n_pos     = t_addr'(left_idx);
                    n_state   = S_DN;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_PEEK: begin
                n_top   = rd_val;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= r_mem[mem_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos    <= n_pos;
        r_mov    <= n_mov;
        r_lval   <= n_lval;
        r_lless  <= n_lless;
        r_top    <= n_top;
        r_status <= n_status;
    end

    assign o_busy               = (r_state != S_IDLE);
    assign o_res.valid          = (r_state == S_DONE);
    assign o_res.item.top_value = r_top;
    assign o_res.item.status    = r_status;
    assign o_res.item.fill_level = t_fill'(r_cnt);

endmodule

### design/binary_min_heap_queue.sv
// Channel  Direction  Valid        Stall        Payload
// input    in         i_in_valid   o_in_stall   i_in_data  (func, push_value)
// output   out        o_out_valid  i_out_stall  o_out_data (top_value, status, fill_level)
//
// One request is handled at a time. A request that finds the heap empty or full is answered
// without touching the heap memory, and a peek reads the root. A push carries the new entry
// up the heap level by level while it is less than its parent. A pop reads the root and the
// last entry, then moves that entry down level by level, at most log2 of the depth minus one.
// The heap memory takes one read and one write per cycle, and its read data is registered.
// The input is stalled until the result enters the output register.
// Reset empties the heap at once. A result waits in the output register while the output
// is stalled, and the next request is taken and worked while it waits.
module binary_min_heap_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  bmhq_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output bmhq_pkg::t_out o_out_data
);
    import bmhq_pkg::*;

    t_req req;
    t_res res;
    logic busy;
    logic take;
    logic r_out_valid;
    t_out r_out_data;

    assign req.start = i_in_valid && !busy;
    assign req.item  = i_in_data;
    assign take      = !r_out_valid || !i_out_stall;

    bmhq_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req),
        .i_res_take (take),
        .o_busy     (busy),
        .o_res      (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take) begin
            r_out_valid <= res.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && res.valid) begin
            r_out_data <= res.item;
        end
    end

    assign o_in_stall  = busy;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

### verif/binary_min_heap_queue_tb.sv
`timescale 1ns / 100ps

module binary_min_heap_queue_tb;

    import bmhq_pkg::*;

    localparam t_func FUNC_PEEK  = 2'd2;
    localparam t_func FUNC_SPARE = 2'd3;

    localparam t_data EMPTY_TOP = -32'sd1;
    localparam t_data KEY_MIN   = 32'sh8000_0000;
    localparam t_data KEY_MAX   = 32'sh7FFF_FFFF;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int QUIET_FROM   = 2_000;
    localparam int QUIET_TO     = 4_000;
    localparam int SETTLE_TIME  = 200;
    localparam int FILL_ITEMS   = 100;
    localparam int RANDOM_BLKS  = 5;
    localparam int BLK_ITEMS    = 50;

    typedef struct {
        t_in req;
        bit  drain_first;
    } t_heap_job;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    t_in  in_data = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    t_out out_data;

    int cycle_cnt = 0;
    int mismatch_cnt = 0;
    logic quiet;

    t_heap_job heap_jobs_q[$];
    t_out      heap_answers_q[$];

    t_data model_mem [DEPTH];
    int    model_cnt = 0;

    binary_min_heap_queue u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
    end

    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
    end

    assign quiet = (cycle_cnt >= QUIET_FROM) && (cycle_cnt < QUIET_TO);

    task automatic report_mismatch(input string msg);
        $display("ERROR at cycle %0d: %s", cycle_cnt, msg);
        mismatch_cnt++;
    endtask

    task automatic add_job(input t_func f, input t_data v, input bit drain_first);
        t_heap_job job;
        job.req.func = f;
        job.req.push_value = v;
        job.drain_first = drain_first;
        heap_jobs_q.push_back(job);
    endtask

    function automatic t_data pick_value();
        case ($urandom_range(0, 9))
            0: return KEY_MIN;
            1: return KEY_MAX;
            2: return EMPTY_TOP;
            3: return '0;
            4, 5, 6: return t_data'($urandom_range(0, 15)) - 8;
            default: return t_data'($urandom());
        endcase
    endfunction

    function automatic t_out heap_model_apply(input t_in req);
        t_out  res;
        int    pos;
        int    up;
        int    best;
        int    lc;
        int    rc;
        t_data tmp;
        res.top_value = '0;
        res.status = ST_OK;
        if (req.func == FUNC_PUSH) begin
            if (model_cnt >= DEPTH) begin
                res.status = ST_FULL;
            end else begin
                pos = model_cnt;
                model_mem[pos] = req.push_value;
                model_cnt++;
                while (pos > 0) begin
                    up = (pos - 1) / 2;
                    if (!(model_mem[pos] < model_mem[up])) break;
                    tmp = model_mem[pos];
                    model_mem[pos] = model_mem[up];
                    model_mem[up] = tmp;
                    pos = up;
                end
            end
        end else if (model_cnt == 0) begin
            res.top_value = EMPTY_TOP;
            res.status = ST_EMPTY;
        end else if (req.func == FUNC_POP) begin
            res.top_value = model_mem[0];
            model_cnt--;
            model_mem[0] = model_mem[model_cnt];
            pos = 0;
            forever begin
                best = pos;
                lc = 2 * pos + 1;
                rc = 2 * pos + 2;
                if (lc < model_cnt && model_mem[lc] < model_mem[best]) best = lc;
                if (rc < model_cnt && model_mem[rc] < model_mem[best]) best = rc;
                if (best == pos) break;
                tmp = model_mem[pos];
                model_mem[pos] = model_mem[best];
                model_mem[best] = tmp;
                pos = best;
            end
        end else begin
            res.top_value = model_mem[0];
        end
        res.fill_level = t_fill'(model_cnt);
        return res;
    endfunction

    // A job marked drain_first is held back until every earlier result has been checked.
    always @(posedge clk) begin : driver
        t_heap_job job;
        if (!rst_n) begin
            in_valid <= 1'b0;
            in_data <= '0;
        end else begin
            if (in_valid && !in_stall) begin
                heap_answers_q.push_back(heap_model_apply(in_data));
            end
            if (!in_valid || !in_stall) begin
                if (heap_jobs_q.size() != 0 && (quiet || $urandom_range(0, 99) >= 14) &&
                    !(heap_jobs_q[0].drain_first && heap_answers_q.size() != 0)) begin
                    job = heap_jobs_q.pop_front();
                    in_valid <= 1'b1;
                    in_data <= job.req;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk) begin : monitor
        t_out want;
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (out_valid && !out_stall) begin
                if (heap_answers_q.size() == 0) begin
                    report_mismatch("result transfer with no request outstanding");
                end else begin
                    want = heap_answers_q.pop_front();
                    if (out_data.top_value !== want.top_value) begin
                        report_mismatch($sformatf("top_value got %0d want %0d",
                                                  out_data.top_value, want.top_value));
                    end
                    if (out_data.status !== want.status) begin
                        report_mismatch($sformatf("status got %0d want %0d",
                                                  out_data.status, want.status));
                    end
                    if (out_data.fill_level !== want.fill_level) begin
                        report_mismatch($sformatf("fill_level got %0d want %0d",
                                                  out_data.fill_level, want.fill_level));
                    end
                end
            end
            out_stall <= !quiet && ($urandom_range(0, 99) < 14);
        end
    end

    initial begin : stimulus
        int push_pct;
        int roll;

        add_job(FUNC_PEEK, KEY_MIN, 1'b0);
        add_job(FUNC_POP, KEY_MAX, 1'b0);
        add_job(FUNC_SPARE, EMPTY_TOP, 1'b0);
        add_job(FUNC_PUSH, KEY_MAX, 1'b0);
        add_job(FUNC_PUSH, KEY_MIN, 1'b0);
        add_job(FUNC_PUSH, '0, 1'b0);
        add_job(FUNC_PUSH, EMPTY_TOP, 1'b0);
        add_job(FUNC_PUSH, 32'sd5, 1'b0);
        add_job(FUNC_PUSH, 32'sd5, 1'b0);
        add_job(FUNC_PUSH, 32'sd5, 1'b0);
        add_job(FUNC_PEEK, '0, 1'b0);
        add_job(FUNC_SPARE, KEY_MAX, 1'b0);
        for (int k = 0; k < 8; k++) begin
            add_job(FUNC_POP, t_data'($urandom()), 1'b0);
        end

        // Build a deep heap, then drain it until a pop finds it empty.
        for (int k = 0; k < FILL_ITEMS; k++) begin
            add_job(FUNC_PUSH, pick_value(), k == 0);
        end
        add_job(FUNC_PUSH, KEY_MIN, 1'b0);
        add_job(FUNC_PUSH, KEY_MAX, 1'b0);
        add_job(FUNC_PUSH, t_data'($urandom()), 1'b0);
        add_job(FUNC_PEEK, '0, 1'b0);
        add_job(FUNC_SPARE, '0, 1'b0);
        for (int k = 0; k <= FILL_ITEMS + 3; k++) begin
            add_job(FUNC_POP, t_data'($urandom()), k == 0);
        end

        // The push share changes from block to block so that the fill rises and falls.
        for (int blk = 0; blk < RANDOM_BLKS; blk++) begin
            case (blk % 3)
                0: push_pct = 75;
                1: push_pct = 50;
                default: push_pct = 25;
            endcase
            for (int k = 0; k < BLK_ITEMS; k++) begin
                roll = $urandom_range(0, 99);
                if (roll < push_pct) begin
                    add_job(FUNC_PUSH, pick_value(), $urandom_range(0, 99) == 0);
                end else begin
                    roll = $urandom_range(0, 9);
                    if (roll < 7) begin
                        add_job(FUNC_POP, t_data'($urandom()), $urandom_range(0, 99) == 0);
                    end else if (roll < 9) begin
                        add_job(FUNC_PEEK, t_data'($urandom()), 1'b0);
                    end else begin
                        add_job(FUNC_SPARE, t_data'($urandom()), 1'b0);
                    end
                end
            end
        end

        @(negedge clk);
        while (heap_jobs_q.size() != 0 || in_valid) @(negedge clk);
        while (heap_answers_q.size() != 0) @(negedge clk);
        repeat (SETTLE_TIME) @(negedge clk);

        if (mismatch_cnt == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin : watchdog
        wait (cycle_cnt >= CYCLE_LIMIT);
        $display("ERROR: run did not finish within %0d cycles", CYCLE_LIMIT);
        $display("FAILED: results differ");
        $finish;
    end

endmodule
